// ----- design/dkv_cfg_pkg.sv -----
// Shared types, character codes and key text for the display key/value parser.
// No dependencies; imported by every module of the block.
package dkv_cfg_pkg;

   localparam int DIM_W = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 14;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_VIDEO_ON = 2'd2;

   localparam logic [DIM_W-1:0] DEFAULT_WIDTH_RESET = 14'd1280;
   localparam logic [DIM_W-1:0] DEFAULT_HEIGHT_RESET = 14'd720;
   localparam logic DEFAULT_VIDEO_ON_RESET = 1'b1;

   // character codes
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_O = 8'h6F;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // key text, first character in the top byte
   localparam int KEY_VIDEO_LEN = 10;
   localparam int KEY_WIDTH_LEN = 5;
   localparam int KEY_HEIGHT_LEN = 6;
   localparam logic [8*KEY_VIDEO_LEN-1:0] KEY_VIDEO_TEXT = {"video", "_mode"};
   localparam logic [8*KEY_WIDTH_LEN-1:0] KEY_WIDTH_TEXT = "width";
   localparam logic [8*KEY_HEIGHT_LEN-1:0] KEY_HEIGHT_TEXT = "height";

   // bit positions of the key match flags
   localparam int KEY_BIT_VIDEO = 0;
   localparam int KEY_BIT_WIDTH = 1;
   localparam int KEY_BIT_HEIGHT = 2;

   // bit positions of the value flags
   localparam int VAL_BIT_ON = 0;
   localparam int VAL_BIT_OFF = 1;
   localparam int VAL_BIT_DIGITS = 2;

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_KEY   = 5'b00010,
      PH_SEP   = 5'b00100,
      PH_VALUE = 5'b01000,
      PH_SKIP  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic             video_on;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } settings_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_buffer;
   } req_beat_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic [7:0] key_char(input int sel, input logic [3:0] pos);
      logic [7:0] ch;
      ch = CH_NUL;
      case (sel)
         KEY_BIT_VIDEO: begin
            if (pos < 4'(KEY_VIDEO_LEN))
               ch = KEY_VIDEO_TEXT[8*(KEY_VIDEO_LEN-1-int'(pos)) +: 8];
         end
         KEY_BIT_WIDTH: begin
            if (pos < 4'(KEY_WIDTH_LEN))
               ch = KEY_WIDTH_TEXT[8*(KEY_WIDTH_LEN-1-int'(pos)) +: 8];
         end
         KEY_BIT_HEIGHT: begin
            if (pos < 4'(KEY_HEIGHT_LEN))
               ch = KEY_HEIGHT_TEXT[8*(KEY_HEIGHT_LEN-1-int'(pos)) +: 8];
         end
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

endpackage

// ----- design/dkv_cfg_req_stage.sv -----
// Input register of the parser: holds one text beat until the parse core takes it.
// Depends on dkv_cfg_pkg.
module dkv_cfg_req_stage
   import dkv_cfg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_text_byte,
   input  logic         req_end_of_buffer,
   input  logic         take,
   output logic         beat_valid,
   output req_beat_type beat
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type beat_ff;
   logic         load;

   // accept a new beat while empty or while the held one leaves
   assign req_ready = !valid_ff || take;
   assign load = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff.text_byte <= req_text_byte;
         beat_ff.end_of_buffer <= req_end_of_buffer;
      end
   end

   assign beat_valid = valid_ff;
   assign beat = beat_ff;

endmodule

// ----- design/dkv_cfg_parse_core.sv -----
// Line parser state and its one-byte step: key/value split, key match, value check.
// Depends on dkv_cfg_pkg.
module dkv_cfg_parse_core
   import dkv_cfg_pkg::*;
#(
   parameter int FIELD_CHARS = 32,
   parameter int MAX_BYTES = 65536,
   parameter int MAX_DIMENSION = 8192
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_beat_type beat,
   input  settings_type defaults,
   output settings_type settle
);

   localparam int KW = $clog2(FIELD_CHARS);
   localparam int NW = $clog2(MAX_DIMENSION + 1);
   localparam int MW = NW + 4;
   localparam int EW = (NW > DIM_W) ? NW : DIM_W;
   localparam int BW = $clog2(MAX_BYTES + 1);

   typedef struct packed {
      phase_type     phase;
      logic [KW-1:0] key_length;
      logic [2:0]    key_flags;
      logic [KW-1:0] value_length;
      logic [2:0]    value_flags;
      logic [NW-1:0] value_number;
   } line_type;

   localparam line_type LINE_CLEAR = '{PH_LEAD, '0, 3'b111, '0, 3'b111, '0};

   line_type     line_ff, line_in;
   logic [BW-1:0] byte_count_ff, byte_count_in;
   logic         stopped_ff, stopped_in;
   settings_type cur_ff, cur_in;

   function automatic line_type add_key(input line_type ln, input logic [7:0] c);
      line_type   r;
      logic [7:0] lc;
      r = ln;
      lc = to_lower(c);
      if (ln.key_length >= KW'(KEY_VIDEO_LEN) ||
          key_char(KEY_BIT_VIDEO, ln.key_length[3:0]) != lc)
         r.key_flags[KEY_BIT_VIDEO] = 1'b0;
      if (ln.key_length >= KW'(KEY_WIDTH_LEN) ||
          key_char(KEY_BIT_WIDTH, ln.key_length[3:0]) != lc)
         r.key_flags[KEY_BIT_WIDTH] = 1'b0;
      if (ln.key_length >= KW'(KEY_HEIGHT_LEN) ||
          key_char(KEY_BIT_HEIGHT, ln.key_length[3:0]) != lc)
         r.key_flags[KEY_BIT_HEIGHT] = 1'b0;
      r.key_length = ln.key_length + KW'(1);
      return r;
   endfunction

   function automatic line_type add_value(input line_type ln, input logic [7:0] c);
      line_type      r;
      logic [7:0]    lc;
      logic [MW-1:0] n;
      r = ln;
      lc = to_lower(c);
      n = MW'({ln.value_number, 3'b000}) + MW'({ln.value_number, 1'b0}) + MW'(c - CH_ZERO);
      if (!((ln.value_length == KW'(0) && lc == CH_LOWER_O) ||
            (ln.value_length == KW'(1) && lc == CH_LOWER_N)))
         r.value_flags[VAL_BIT_ON] = 1'b0;
      if (!((ln.value_length == KW'(0) && lc == CH_LOWER_O) ||
            ((ln.value_length == KW'(1) || ln.value_length == KW'(2)) && lc == CH_LOWER_F)))
         r.value_flags[VAL_BIT_OFF] = 1'b0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (ln.value_flags[VAL_BIT_DIGITS]) begin
            if (n > MW'(MAX_DIMENSION))
               r.value_flags[VAL_BIT_DIGITS] = 1'b0;
            else
               r.value_number = n[NW-1:0];
         end
      end else begin
         r.value_flags[VAL_BIT_DIGITS] = 1'b0;
      end
      r.value_length = ln.value_length + KW'(1);
      return r;
   endfunction

   function automatic settings_type apply_line(input line_type ln, input settings_type cur);
      settings_type  s;
      logic          num_ok;
      logic [EW-1:0] num_ext;
      s = cur;
      num_ext = EW'(ln.value_number);
      num_ok = ln.value_flags[VAL_BIT_DIGITS] && (ln.value_length != '0) &&
               (ln.value_number != '0);
      if (ln.key_flags[KEY_BIT_VIDEO] && ln.key_length == KW'(KEY_VIDEO_LEN)) begin
         if (ln.value_flags[VAL_BIT_ON] && ln.value_length == KW'(2))
            s.video_on = 1'b1;
         else if (ln.value_flags[VAL_BIT_OFF] && ln.value_length == KW'(3))
            s.video_on = 1'b0;
      end else if (ln.key_flags[KEY_BIT_WIDTH] && ln.key_length == KW'(KEY_WIDTH_LEN)) begin
         if (num_ok)
            s.width = num_ext[DIM_W-1:0];
      end else if (ln.key_flags[KEY_BIT_HEIGHT] && ln.key_length == KW'(KEY_HEIGHT_LEN)) begin
         if (num_ok)
            s.height = num_ext[DIM_W-1:0];
      end
      return s;
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       blank;
      logic       capped;
      logic       sep_char;
      c = beat.text_byte;
      blank = is_blank(c);
      sep_char = blank || (c == CH_EQUAL);
      capped = 1'b0;
      line_in = line_ff;
      byte_count_in = byte_count_ff;
      stopped_in = stopped_ff;
      cur_in = cur_ff;
      settle = cur_ff;
      if (step_en) begin
         if (!stopped_ff) begin
            // first byte of a parse: load the defaults
            if (byte_count_ff == '0)
               cur_in = defaults;
            byte_count_in = byte_count_ff + BW'(1);
            capped = byte_count_in >= BW'(MAX_BYTES);
            if (c == CH_LF || c == CH_NUL) begin
               if (line_in.phase == PH_VALUE)
                  cur_in = apply_line(line_in, cur_in);
               line_in = LINE_CLEAR;
               if (c == CH_NUL)
                  stopped_in = 1'b1;
            end else begin
               case (line_in.phase)
                  PH_LEAD: begin
                     if (!blank) begin
                        if (c == CH_HASH || c == CH_EQUAL) begin
                           line_in.phase = PH_SKIP;
                        end else begin
                           line_in.phase = PH_KEY;
                           line_in = add_key(line_in, c);
                        end
                     end
                  end
                  PH_KEY: begin
                     if (sep_char)
                        line_in.phase = PH_SEP;
                     else if (line_in.key_length >= KW'(FIELD_CHARS - 1))
                        line_in.phase = PH_SKIP;
                     else
                        line_in = add_key(line_in, c);
                  end
                  PH_SEP: begin
                     if (!sep_char) begin
                        if (c == CH_HASH) begin
                           line_in.phase = PH_SKIP;
                        end else begin
                           line_in.phase = PH_VALUE;
                           line_in = add_value(line_in, c);
                        end
                     end
                  end
                  PH_VALUE: begin
                     if (blank || c == CH_HASH) begin
                        cur_in = apply_line(line_in, cur_in);
                        line_in.phase = PH_SKIP;
                     end else if (line_in.value_length < KW'(FIELD_CHARS - 1)) begin
                        line_in = add_value(line_in, c);
                     end
                  end
                  default: begin
                  end
               endcase
               // close the open line on the last byte of the text or at the byte cap
               if (beat.end_of_buffer || capped) begin
                  if (line_in.phase == PH_VALUE)
                     cur_in = apply_line(line_in, cur_in);
                  line_in = LINE_CLEAR;
               end
            end
            if (capped)
               stopped_in = 1'b1;
         end
         settle = cur_in;
         if (beat.end_of_buffer) begin
            line_in = LINE_CLEAR;
            byte_count_in = '0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= LINE_CLEAR;
         byte_count_ff <= '0;
         stopped_ff <= 1'b0;
      end else begin
         line_ff <= line_in;
         byte_count_ff <= byte_count_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- design/display_key_value_config_parser.sv -----
// Display key/value config parser: one text byte per beat, one result per buffer.
// The last byte's beat is held in the input register, then its result is registered.
// Throughput: one byte per cycle, set by the parse step; a result
// held by rsp_ready stalls the input. Reset: synchronous; defaults return to
// 1280x720 with video on and the parse restarts in the leading whitespace phase.
// Depends on dkv_cfg_pkg and submodules.
module display_key_value_config_parser
   import dkv_cfg_pkg::*;
#(
   parameter int FIELD_CHARS = 32,
   parameter int MAX_BYTES = 65536,
   parameter int MAX_DIMENSION = 8192
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_buffer,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_video_on,
   output logic [DIM_W-1:0]       rsp_screen_width,
   output logic [DIM_W-1:0]       rsp_screen_height,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   settings_type defaults_ff, defaults_in;
   settings_type rsp_ff;
   settings_type settle;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         beat_valid;
   req_beat_type beat;
   logic         step_en;

   always_comb begin
      defaults_in = defaults_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DEFAULT_WIDTH:    defaults_in.width = csr_wdata[DIM_W-1:0];
            CSR_DEFAULT_HEIGHT:   defaults_in.height = csr_wdata[DIM_W-1:0];
            CSR_DEFAULT_VIDEO_ON: defaults_in.video_on = csr_wdata[0];
            default:              defaults_in = defaults_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         defaults_ff <= '{DEFAULT_VIDEO_ON_RESET, DEFAULT_WIDTH_RESET, DEFAULT_HEIGHT_RESET};
      end else begin
         defaults_ff <= defaults_in;
      end
   end

   dkv_cfg_req_stage u_req_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .take              (step_en),
      .beat_valid        (beat_valid),
      .beat              (beat)
   );

   // advance the parse only while the result register can take a beat
   assign step_en = beat_valid && (!rsp_valid_ff || rsp_ready);

   dkv_cfg_parse_core #(
      .FIELD_CHARS   (FIELD_CHARS),
      .MAX_BYTES     (MAX_BYTES),
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_parse_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .beat     (beat),
      .defaults (defaults_ff),
      .settle   (settle)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en && beat.end_of_buffer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && beat.end_of_buffer) begin
         rsp_ff <= settle;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_video_on = rsp_ff.video_on;
   assign rsp_screen_width = rsp_ff.width;
   assign rsp_screen_height = rsp_ff.height;

`ifndef SYNTH
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !beat_valid |-> req_ready)
      else $error("input register empty but not ready");

   a_last_loads_result: assert property (@(posedge clock) disable iff (reset)
      step_en && beat.end_of_buffer |=> rsp_valid)
      else $error("last byte did not load a result");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_en && beat.end_of_buffer))
      else $error("result appeared without a last byte");
`endif

endmodule
